### rtl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

	localparam int DATA_W      = 32;
	localparam int POS_W       = 5;
	localparam int COUNT_OUT_W = 5;
	localparam int MAX_RESULTS = 16;
	localparam int CAPACITY_DEF = 16;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_LIST   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_ROTATE = 2'd3
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_REPORT = 2'd1,
		S_LIST   = 2'd2
	} state_t;

	// command broadcast along the chain
	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   value;
	} cell_cmd_t;

endpackage

### rtl/ple_cell.sv
`timescale 1ns / 1ps

module ple_cell #(
	parameter int IDXW = 5,
	parameter int IDX  = 0
) (
	input  logic                      clk,
	input  ple_pkg::cell_cmd_t        ccmd,
	input  logic [IDXW-1:0]           pos_idx,
	input  logic [IDXW-1:0]           last_idx,
	input  logic [ple_pkg::DATA_W-1:0] left,
	input  logic [ple_pkg::DATA_W-1:0] right,
	input  logic [ple_pkg::DATA_W-1:0] head,
	output logic [ple_pkg::DATA_W-1:0] data,
	output logic [ple_pkg::DATA_W-1:0] tail_part
);
	import ple_pkg::*;

	localparam logic [IDXW-1:0] MY = IDXW'(IDX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (ccmd.op)
			OP_INSERT: begin
				if (MY == pos_idx) begin
					data_d = ccmd.value;
				end else if (MY > pos_idx) begin
					data_d = left;
				end
			end
			OP_DELETE: begin
				if (MY >= pos_idx) begin
					data_d = right;
				end
			end
			OP_ROTATE: begin
				// rotate only the occupied part, head wraps to the tail slot
				if (MY == last_idx) begin
					data_d = head;
				end else if (MY < last_idx) begin
					data_d = right;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data      = data_q;
	assign tail_part = (MY == last_idx) ? data_q : '0;

endmodule

### rtl/positional_list_engine_unit.sv
`timescale 1ns / 1ps

// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------------
// command   | start in, busy out        | cmd, position, value
// result    | valid out, no back-press  | status, item_value, tail_value,
//           |                           | element_count, last
//
// insert, delete and unused commands: the chain shifts at the accepting edge,
// and the result shows in the following cycle.
// list: the chain rotates its occupied cells one place a cycle and the head cell
// is streamed, at most 16 results.
// arst_n clears the controller and the count; cell contents need no reset.
// the receiver cannot stall; each result is a one-cycle transfer marked by valid.

module positional_list_engine_unit #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      cmd,
	input  logic [ple_pkg::POS_W-1:0]       position,
	input  logic signed [ple_pkg::DATA_W-1:0] value,
	output logic                            valid,
	output logic [1:0]                      status,
	output logic signed [ple_pkg::DATA_W-1:0] item_value,
	output logic signed [ple_pkg::DATA_W-1:0] tail_value,
	output logic [ple_pkg::COUNT_OUT_W-1:0] element_count,
	output logic                            last
);
	import ple_pkg::*;

	// count width holds CAPACITY itself; compare width covers position and count+1
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_t           state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    idx_q, idx_d;
	status_t          status_q, status_d;
	logic [DATA_W-1:0] tail_hold_q;

	cell_cmd_t        ccmd;
	logic [CW-1:0]    pos_idx;
	logic [CW-1:0]    last_idx;

	logic [DATA_W-1:0] cell_val  [CAPACITY];
	logic [DATA_W-1:0] tail_part [CAPACITY];
	logic [DATA_W-1:0] tail_now;
	logic [DATA_W-1:0] head_now;

	logic [CMPW-1:0]   pos_ext;
	logic [CMPW-1:0]   cnt_ext;
	logic [CMPW-1:0]   n_list;
	logic              ins_bad, del_bad, is_full, is_empty;

	assign pos_ext  = CMPW'(position);
	assign cnt_ext  = CMPW'(count_q);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(CAPACITY));
	assign ins_bad  = (position == '0) || (pos_ext > cnt_ext + CMPW'(1));
	assign del_bad  = (position == '0) || (pos_ext > cnt_ext);
	assign pos_idx  = CW'(position - POS_W'(1));
	assign last_idx = count_q - CW'(1);
	// list emits at most MAX_RESULTS of the held elements
	assign n_list   = (cnt_ext > CMPW'(MAX_RESULTS)) ? CMPW'(MAX_RESULTS) : cnt_ext;

	// the cell chain
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_v, right_v;
		if (g == 0) begin : g_first
			assign left_v = cell_val[0];
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end
		if (g == CAPACITY - 1) begin : g_end
			assign right_v = cell_val[CAPACITY-1];
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end
		ple_cell #(
			.IDXW (CW),
			.IDX  (g)
		) u_cell (
			.clk       (clk),
			.ccmd      (ccmd),
			.pos_idx   (pos_idx),
			.last_idx  (last_idx),
			.left      (left_v),
			.right     (right_v),
			.head      (cell_val[0]),
			.data      (cell_val[g]),
			.tail_part (tail_part[g])
		);
	end

	// only the tail cell drives a nonzero part
	always_comb begin
		tail_now = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_now = tail_now | tail_part[i];
		end
		if (is_empty) begin
			tail_now = '0;
		end
	end

	assign head_now = is_empty ? '0 : cell_val[0];

	// controller: next state, chain command and result outputs
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		status_d   = status_q;
		ccmd.op    = OP_HOLD;
		ccmd.value = value;
		busy       = 1'b1;
		valid      = 1'b0;
		last       = 1'b0;
		status     = ST_OK;
		item_value = head_now;
		tail_value = tail_now;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d  = S_REPORT;
					status_d = ST_OK;
					case (cmd)
						CMD_INSERT: begin
							if (ins_bad) begin
								status_d = ST_BAD_POS;
							end else if (is_full) begin
								status_d = ST_FULL;
							end else begin
								ccmd.op = OP_INSERT;
								count_d = count_q + CW'(1);
							end
						end
						CMD_DELETE: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else if (del_bad) begin
								status_d = ST_BAD_POS;
							end else begin
								ccmd.op = OP_DELETE;
								count_d = count_q - CW'(1);
							end
						end
						CMD_LIST: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_LIST;
								idx_d   = '0;
							end
						end
						default: status_d = ST_BAD_POS;
					endcase
				end
			end
			S_REPORT: begin
				valid   = 1'b1;
				last    = 1'b1;
				status  = status_q;
				state_d = S_IDLE;
			end
			S_LIST: begin
				ccmd.op    = OP_ROTATE;
				valid      = (CMPW'(idx_q) < n_list);
				last       = (CMPW'(idx_q) == n_list - CMPW'(1));
				item_value = cell_val[0];
				// tail cell moves while rotating: hold the value seen at the start
				tail_value = (idx_q == '0) ? tail_now : tail_hold_q;
				idx_d      = idx_q + CW'(1);
				if (idx_q == last_idx) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign element_count = COUNT_OUT_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LIST && idx_q == '0) begin
			tail_hold_q <= tail_now;
		end
	end

endmodule

### rtl/ple_checker.sv
`timescale 1ns / 1ps

module ple_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic [1:0]                      cmd,
	input logic [ple_pkg::POS_W-1:0]       position,
	input logic [ple_pkg::DATA_W-1:0]      value,
	input logic                            valid,
	input logic [1:0]                      status,
	input logic [ple_pkg::DATA_W-1:0]      item_value,
	input logic [ple_pkg::DATA_W-1:0]      tail_value,
	input logic [ple_pkg::COUNT_OUT_W-1:0] element_count,
	input logic                            last
);
	import ple_pkg::*;

	// results only come while a command is in flight
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy)
		else $error("result transfer while idle");

	// the final result closes the burst
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |=> !valid)
		else $error("result transfer after last");

	// position zero is never a valid insert
	a_ins_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_INSERT && position == '0)
		|=> (valid && last && status == ST_BAD_POS))
		else $error("insert at position zero not flagged");

	// empty status carries no elements
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status == ST_EMPTY) |-> (last && tail_value == '0 && item_value == '0))
		else $error("empty result carries data");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ple_pkg::*;

	// list depth used both by the block and by the tracker below
	localparam int CAP         = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	// cmd code 3 has no enum member in the package; the block answers it as a bad position
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// one result as the block should present it
	typedef struct {
		status_t                   status;
		logic signed [DATA_W-1:0]  item;
		logic signed [DATA_W-1:0]  tail;
		logic [COUNT_OUT_W-1:0]    count;
		logic                      last;
	} list_report_t;

	// shadow copy of the list plus the queue of results still owed by the block
	class list_tracker;
		logic signed [DATA_W-1:0] cells [CAP];
		int held;
		list_report_t owed [$];
		int failures;
		int commands;
		int checked;
		int status_seen [4];
		int full_lists;

		function new();
			held = 0;
			failures = 0;
			commands = 0;
			checked = 0;
			full_lists = 0;
			foreach (status_seen[k]) status_seen[k] = 0;
		endfunction

		function void push_report(status_t st, logic signed [DATA_W-1:0] item, logic lst);
			list_report_t r;
			r.status = st;
			r.item   = item;
			r.tail   = (held != 0) ? cells[held-1] : '0;
			r.count  = held[COUNT_OUT_W-1:0];
			r.last   = lst;
			owed.push_back(r);
		endfunction

		// called at the edge where a command transfer happens
		function void note_command(logic [1:0] c, logic [POS_W-1:0] p,
				logic signed [DATA_W-1:0] v);
			int pos;
			int n;
			status_t st;
			pos = int'(p);
			st = ST_OK;
			commands++;
			if (c == CMD_LIST) begin
				if (held == 0) begin
					push_report(ST_EMPTY, '0, 1'b1);
				end else begin
					n = (held > MAX_RESULTS) ? MAX_RESULTS : held;
					if (n == CAP) full_lists++;
					for (int i = 0; i < n; i++)
						push_report(ST_OK, cells[i], i == n - 1);
				end
				return;
			end
			if (c == CMD_INSERT) begin
				if (pos == 0 || pos > held + 1) begin
					st = ST_BAD_POS;
				end else if (held >= CAP) begin
					st = ST_FULL;
				end else begin
					for (int i = held; i >= pos; i--)
						cells[i] = cells[i-1];
					cells[pos-1] = v;
					held++;
				end
			end else if (c == CMD_DELETE) begin
				if (held == 0) begin
					st = ST_EMPTY;
				end else if (pos == 0 || pos > held) begin
					st = ST_BAD_POS;
				end else begin
					for (int i = pos - 1; i + 1 < held; i++)
						cells[i] = cells[i+1];
					held--;
				end
			end else begin
				st = ST_BAD_POS;
			end
			push_report(st, (held != 0) ? cells[0] : '0, 1'b1);
		endfunction

		// called at every edge where valid is high
		function void check_report(logic [1:0] s, logic signed [DATA_W-1:0] iv,
				logic signed [DATA_W-1:0] tv, logic [COUNT_OUT_W-1:0] ec, logic l);
			list_report_t e;
			checked++;
			status_seen[s]++;
			if (owed.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$write("ERROR: result with nothing owed: status %0d item %0d", s, iv);
					$display(" tail %0d count %0d last %0d", tv, ec, l);
				end
				return;
			end
			e = owed.pop_front();
			if (s !== e.status || iv !== e.item || tv !== e.tail || ec !== e.count ||
					l !== e.last) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$write("ERROR: result %0d: expected status %0d item %0d tail %0d",
						checked, e.status, e.item, e.tail);
					$write(" count %0d last %0d,", e.count, e.last);
					$display(" got status %0d item %0d tail %0d count %0d last %0d",
						s, iv, tv, ec, l);
				end
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               cmd;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     valid;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] item_value;
	logic signed [DATA_W-1:0] tail_value;
	logic [COUNT_OUT_W-1:0]   element_count;
	logic                     last;

	list_tracker tracker;
	int idle_pct;
	int cycle_count;

	positional_list_engine_unit #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.position(position),
		.value(value),
		.valid(valid),
		.status(status),
		.item_value(item_value),
		.tail_value(tail_value),
		.element_count(element_count),
		.last(last)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// free-running cycle counter for the watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog: a hung handshake or a lost result ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// result monitor: the block cannot be stalled, so every strobe is a transfer
	always @(posedge clk) begin
		if (arst_n === 1'b1 && valid === 1'b1)
			tracker.check_report(status, item_value, tail_value, element_count, last);
	end

	// one command transfer; entered and left at a falling edge, start left high
	// so back-to-back commands never drop start in between
	task automatic issue(input logic [1:0] c, input logic [POS_W-1:0] p,
			input logic signed [DATA_W-1:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start    = 1'b1;
		cmd      = c;
		position = p;
		value    = v;
		forever begin
			@(posedge clk);
			if (busy === 1'b0) break;
		end
		tracker.note_command(c, p, v);
		@(negedge clk);
	endtask

	// random command, biased toward filling or draining the list
	task automatic issue_random(input bit grow);
		int r;
		int held_now;
		logic [1:0] c;
		logic [POS_W-1:0] p;
		logic signed [DATA_W-1:0] v;
		held_now = tracker.held;
		r = $urandom_range(0, 99);
		if (r < 4)
			c = CMD_UNUSED;
		else if (r < 14)
			c = CMD_LIST;
		else if (r < (grow ? 76 : 34))
			c = CMD_INSERT;
		else
			c = CMD_DELETE;
		// mostly legal positions, some noise across the whole field
		if ($urandom_range(0, 99) < 8)
			p = POS_W'($urandom_range(0, 31));
		else if (c == CMD_DELETE)
			p = (held_now == 0) ? POS_W'(1) : POS_W'($urandom_range(1, held_now));
		else
			p = POS_W'($urandom_range(1, held_now + 1));
		case ($urandom_range(0, 9))
			0: v = 32'sh7fffffff;
			1: v = 32'sh80000000;
			2: v = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
			default: v = $urandom;
		endcase
		issue(c, p, v);
	endtask

	initial begin
		tracker  = new();
		idle_pct = 15;
		arst_n   = 1'b0;
		start    = 1'b0;
		cmd      = CMD_INSERT;
		position = '0;
		value    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty-list answers first
		issue(CMD_LIST,   5'd0, 32'sd0);
		issue(CMD_DELETE, 5'd1, 32'sd0);
		issue(CMD_UNUSED, 5'd0, 32'sd0);
		// insert positions outside the list
		issue(CMD_INSERT, 5'd0, 32'sd11);
		issue(CMD_INSERT, 5'd2, 32'sd12);
		// first insert into an empty list sets head and tail together
		issue(CMD_INSERT, 5'd1, 32'sh7fffffff);
		// append at the tail, insert at the head, insert in the middle
		issue(CMD_INSERT, 5'd2, 32'sh80000000);
		issue(CMD_INSERT, 5'd1, 32'sd0);
		issue(CMD_INSERT, 5'd3, -32'sd1);
		issue(CMD_LIST,   5'd0, 32'sd0);
		// delete and insert positions outside the list
		issue(CMD_DELETE, 5'd0, 32'sd0);
		issue(CMD_DELETE, 5'd5, 32'sd0);
		issue(CMD_INSERT, 5'd6, 32'sd0);
		issue(CMD_INSERT, 5'd31, 32'sh55555555);
		// delete in the middle, at the tail, at the head
		issue(CMD_DELETE, 5'd2, 32'sd0);
		issue(CMD_DELETE, 5'd3, 32'sd0);
		issue(CMD_DELETE, 5'd1, 32'sd0);
		issue(CMD_UNUSED, 5'd17, -32'sd1);
		issue(CMD_LIST,   5'd16, 32'shaaaaaaaa);
		issue(CMD_DELETE, 5'd1, 32'sd0);

		// random: sender idles 15%, then 59%, then never; the list
		// fills and drains in windows of 60 commands so full is reached
		for (int i = 0; i < 410; i++) begin
			if (i == 140) idle_pct = 59;
			if (i == 275) idle_pct = 0;
			issue_random(((i / 60) % 2) == 0);
		end
		start = 1'b0;

		// wait for every owed result, then keep watching for stray strobes
		while (tracker.owed.size() != 0) @(posedge clk);
		repeat (2 * MAX_RESULTS + 4) @(posedge clk);

		$display("covered %0d commands and %0d results, %0d full-length lists",
			tracker.commands, tracker.checked, tracker.full_lists);
		$display("results by status: ok %0d, bad position %0d, full %0d, empty %0d",
			tracker.status_seen[ST_OK], tracker.status_seen[ST_BAD_POS],
			tracker.status_seen[ST_FULL], tracker.status_seen[ST_EMPTY]);
		if (tracker.failures == 0 && tracker.owed.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("mismatches: %0d", tracker.failures);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_unit.sv
rtl/ple_checker.sv
tb/testbench.sv
